[rtl/combination_unrank_assert.svh]
// assertion macros for the combination unrank block
`ifndef COMBINATION_UNRANK_ASSERT_SVH
`define COMBINATION_UNRANK_ASSERT_SVH

`define CU_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

`define CU_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[rtl/cu_pkg.sv]
`timescale 1ns / 1ps
package cu_pkg;
   localparam int MAX_N_DEF = 64;
   localparam int MAX_K_DEF = 16;
   localparam int RESULT_CAP = 16;
   localparam int SIZE_W = 5;
   localparam int RANK_W = 63;
   localparam int ELEM_W = 6;
   localparam int POS_W = 4;
   localparam int BIN_W = 64;

   typedef logic [RESULT_CAP:0][BIN_W-1:0] brow_type;

   // C(n,0..RESULT_CAP), zero where r > n; elaboration only
   function automatic brow_type binom_row(input int n);
      brow_type         brow;
      logic [BIN_W-1:0] acc;
      acc = BIN_W'(1);
      brow = '0;
      for (int r = 0; r <= RESULT_CAP; r++) begin
         if (r > 0) acc = acc * BIN_W'(n - r + 1) / BIN_W'(r);
         brow[r] = acc;
      end
      return brow;
   endfunction
endpackage

[rtl/cu_if.sv]
`timescale 1ns / 1ps
interface cu_req_if;
   import cu_pkg::*;
   logic                valid;
   logic                ready;
   logic [SIZE_W-1:0]   subset_size;
   logic [RANK_W-1:0]   rank_in;
   modport source (output valid, subset_size, rank_in, input ready);
   modport sink (input valid, subset_size, rank_in, output ready);
endinterface

interface cu_rsp_if;
   import cu_pkg::*;
   logic                valid;
   logic                ready;
   logic [ELEM_W-1:0]   element;
   logic [POS_W-1:0]    position;
   logic                last;
   logic                out_of_range;
   modport source (output valid, element, position, last, out_of_range, input ready);
   modport sink (input valid, element, position, last, out_of_range, output ready);
endinterface

[rtl/cu_cell.sv]
`timescale 1ns / 1ps
// one candidate element e: compares C(e,pos) against the residual
module cu_cell #(
   parameter int ELEM = 0
) (
   input  logic              clock,
   input  logic              load,
   input  logic [4:0]        pos,
   input  logic [63:0]       resid,
   input  logic              hit_prev,
   output logic              hit,
   output logic [63:0]       bval
);
   import cu_pkg::*;
   localparam brow_type BROW = binom_row(ELEM);
   logic [63:0] bin_ff, bin_in;
   always_comb begin
      bin_in = BROW[pos];
   end
   always_ff @(posedge clock) begin
      if (load) bin_ff <= bin_in;
   end
   assign hit = hit_prev | (bin_ff <= resid);
   assign bval = bin_ff;
endmodule

[rtl/combination_unrank.sv]
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | subset_size, rank_in
// rsp     | out | element, position, last, out_of_range
// Each item is first accepted in ST_IDLE; then per slot ST_LOAD loads
// C(e,pos) into the row of MAX_N cells and ST_EMIT selects the largest fitting
// cell and emits a word. Reset is synchronous and clears control only.
// A stalled rsp holds the word and the row; the next req is taken once the
// last word sits in the output register.
module combination_unrank #(
   parameter int MAX_N = cu_pkg::MAX_N_DEF,
   parameter int MAX_K = cu_pkg::MAX_K_DEF
) (
   input logic clock,
   input logic reset,
   cu_req_if.sink   req,
   cu_rsp_if.source rsp
);
   import cu_pkg::*;
   `include "combination_unrank_assert.svh"
   localparam int KLIM = (MAX_K < RESULT_CAP) ? MAX_K : RESULT_CAP;
   localparam brow_type NROW = binom_row(MAX_N);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001, ST_LOAD = 3'b010, ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  pos_ff, pos_in;
   logic [63:0] resid_ff, resid_in;
   logic        oor_ff, oor_in;
   logic        ov_ff, ov_in;
   logic [ELEM_W-1:0] el_ff, el_in;
   logic [POS_W-1:0]  po_ff, po_in;
   logic        la_ff, la_in;
   logic        oo_ff, oo_in;

   logic [MAX_N:0] hit;
   logic [63:0] bv [MAX_N];
   assign hit[MAX_N] = 1'b0;

   for (genvar g = 0; g < MAX_N; g++) begin : g_cell
      cu_cell #(.ELEM(g)) u_cell (
         .clock(clock), .load(state_ff == ST_LOAD), .pos(pos_ff), .resid(resid_ff),
         .hit_prev(1'b0), .hit(hit[g]), .bval(bv[g]));
   end

   logic [4:0]  kk;
   logic [ELEM_W-1:0] esel;
   logic [63:0] bsel;
   always_comb begin
      kk = (req.subset_size > 5'(KLIM)) ? 5'(KLIM) : req.subset_size;
      esel = ELEM_W'(int'(pos_ff) - 1);
      bsel = '0;
      for (int i = 0; i < MAX_N; i++) begin
         if (i + 1 >= int'(pos_ff) && hit[i]) begin
            esel = ELEM_W'(i);
            bsel = bv[i];
         end
      end
   end

   wire busy_out = ov_ff && !rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; resid_in = resid_ff; oor_in = oor_ff;
      ov_in = ov_ff && !rsp.ready;
      el_in = el_ff; po_in = po_ff; la_in = la_ff; oo_in = oo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready && kk != 5'd0) begin
               pos_in = kk;
               resid_in = {1'b0, req.rank_in};
               oor_in = ({1'b0, req.rank_in} >= NROW[kk]);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!busy_out) begin
               ov_in = 1'b1;
               el_in = oor_ff ? '0 : esel;
               po_in = POS_W'(pos_ff - 5'd1);
               la_in = (pos_ff == 5'd1);
               oo_in = oor_ff;
               if (!oor_ff) resid_in = resid_ff - bsel;
               pos_in = pos_ff - 5'd1;
               state_in = (pos_ff == 5'd1) ? ST_IDLE : ST_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      pos_ff <= pos_in; resid_ff <= resid_in; oor_ff <= oor_in;
      el_ff <= el_in; po_ff <= po_in; la_ff <= la_in; oo_ff <= oo_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.element = el_ff;
   assign rsp.position = po_ff;
   assign rsp.last = la_ff;
   assign rsp.out_of_range = oo_ff;

   `CU_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `CU_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.element))
   `CU_ASSERT_IMP(a_oor_zero, clock, reset, rsp.valid && rsp.out_of_range, rsp.element == '0)
endmodule
